// File: sv/sirs_pkg.sv
// Package for the signed integer to radix symbol converter.
// Holds the shared constants, register indexes and the controller/datapath structs.
// No dependencies.
`timescale 1ns / 1ps

package sirs_pkg;

  localparam int SYM_W        = 8;
  localparam int NUM_W        = 32;
  localparam int RADIX_W      = 5;
  localparam int DIGIT_W      = 4;
  localparam int ALPHA_N      = 16;
  localparam int MAX_SYMBOLS  = 16;
  localparam int STORE_DEPTH  = 32;
  localparam int ADDR_W       = $clog2(STORE_DEPTH);
  localparam int CNT_W        = ADDR_W + 1;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 64;

  // The divider retires this many quotient bits per cycle.
  localparam int DIV_BITS     = 8;
  localparam int DIV_CYCLES   = NUM_W / DIV_BITS;
  localparam int STEP_W       = $clog2(DIV_CYCLES);

  localparam logic [SYM_W-1:0] SIGN_MINUS = 8'h2D;
  localparam logic [SYM_W-1:0] SIGN_PLUS  = 8'h2B;

  localparam logic [CFG_IDX_W-1:0] REG_RADIX  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYM_LO = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SYM_HI = 2'd2;

  localparam logic [RADIX_W-1:0]    RADIX_RST  = 5'd10;
  localparam logic [CFG_DATA_W-1:0] SYM_LO_RST = 64'h3736_3534_3332_3130;
  localparam logic [CFG_DATA_W-1:0] SYM_HI_RST = 64'h0;

  typedef struct packed {
    logic load;       // capture the incoming number
    logic div_step;   // run one slice of the divider
    logic div_last;   // final slice of a digit: store it, update count
    logic rd;         // read the digit store at count - 1
    logic out_sign;   // load '-' into the output register
    logic out_digit;  // load the looked-up symbol into the output register
    logic out_err;    // load the invalid-alphabet result
  } sirs_cmd_t;

  typedef struct packed {
    logic alpha_ok;
    logic neg;
    logic out_free;
    logic quot_zero;
    logic cnt_full;
    logic cnt_one;
  } sirs_sts_t;

endpackage

// File: sv/signed_int_to_radix_symbols.sv
// Signed integer to radix symbols: one item in, its digits out as alphabet symbols.
// Sequence: accept, alphabet check, then divider slices for each digit (8 quotient bits per cycle).
// Output: a sign step ('-' if negative), then for each digit a store read and an output load.
// One item at a time: in_stall stays high until the item's last symbol (up to 32 digits) is loaded.
// Reset (rst_n low, synchronous): idle, output empty, radix 10, alphabet "01234567".
// The digit store is not cleared; every entry is written before it is read.
`timescale 1ns / 1ps

module signed_int_to_radix_symbols import sirs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic signed [NUM_W-1:0] in_number,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [SYM_W-1:0]      out_symbol,
  output logic                  out_last,
  output logic                  out_alphabet_invalid
);

  sirs_cmd_t cmd;
  sirs_sts_t sts;

  sirs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  sirs_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_number            (NUM_W'(unsigned'(in_number))),
    .cmd                  (cmd),
    .sts                  (sts),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_symbol           (out_symbol),
    .out_last             (out_last),
    .out_alphabet_invalid (out_alphabet_invalid)
  );

endmodule

// File: sv/sirs_dp.sv
// Datapath of the radix converter: configuration registers, alphabet check,
// sliced divider, digit store and output register. Depends on sirs_pkg.
`timescale 1ns / 1ps

module sirs_dp import sirs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [NUM_W-1:0]      in_number,
  input  sirs_cmd_t             cmd,
  output sirs_sts_t             sts,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [SYM_W-1:0]      out_symbol,
  output logic                  out_last,
  output logic                  out_alphabet_invalid
);

  logic [RADIX_W-1:0]    radix_r;
  logic [CFG_DATA_W-1:0] sym_lo_r;
  logic [CFG_DATA_W-1:0] sym_hi_r;

  logic [SYM_W-1:0]      sym [ALPHA_N];
  logic                  alpha_ok;

  logic [NUM_W-1:0]      mag_r;
  logic [NUM_W-1:0]      mag_nxt;
  logic [DIGIT_W-1:0]    rem_r;
  logic [DIGIT_W-1:0]    rem_nxt;
  logic                  neg_r;
  logic [CNT_W-1:0]      cnt_r;

  logic [DIGIT_W-1:0]    store [STORE_DEPTH];
  logic [DIGIT_W-1:0]    rd_data_r;
  logic [ADDR_W-1:0]     rd_addr;

  logic                  out_valid_r;
  logic [SYM_W-1:0]      out_symbol_r;
  logic                  out_last_r;
  logic                  out_inv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r  <= RADIX_RST;
      sym_lo_r <= SYM_LO_RST;
      sym_hi_r <= SYM_HI_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RADIX:  radix_r  <= cfg_data[RADIX_W-1:0];
        REG_SYM_LO: sym_lo_r <= cfg_data;
        REG_SYM_HI: sym_hi_r <= cfg_data;
        default:    ;
      endcase
    end
  end

  for (genvar g = 0; g < ALPHA_N; g++) begin : g_sym
    if (g < ALPHA_N / 2) begin : g_lo
      assign sym[g] = sym_lo_r[g*SYM_W +: SYM_W];
    end else begin : g_hi
      assign sym[g] = sym_hi_r[(g - ALPHA_N/2)*SYM_W +: SYM_W];
    end
  end

  // The alphabet is usable when its length is in range and every symbol in
  // use is nonzero, not a sign character and distinct from all others.
  always_comb begin
    alpha_ok = (radix_r >= RADIX_W'(2)) && (radix_r <= RADIX_W'(MAX_SYMBOLS));
    for (int i = 0; i < ALPHA_N; i++) begin
      if (RADIX_W'(i) < radix_r) begin
        if (sym[i] == '0 || sym[i] == SIGN_MINUS || sym[i] == SIGN_PLUS) begin
          alpha_ok = 1'b0;
        end
        for (int j = 0; j < i; j++) begin
          if (sym[j] == sym[i]) begin
            alpha_ok = 1'b0;
          end
        end
      end
    end
  end

  // One slice of restoring division: the remainder stays below the radix,
  // so four bits hold it between steps.
  always_comb begin
    logic [RADIX_W-1:0] r;
    logic [RADIX_W-1:0] t;
    logic [NUM_W-1:0]   q;
    logic               ge;
    r = {1'b0, rem_r};
    q = mag_r;
    for (int k = 0; k < DIV_BITS; k++) begin
      t  = {r[DIGIT_W-1:0], q[NUM_W-1]};
      ge = (t >= radix_r);
      q  = {q[NUM_W-2:0], ge};
      r  = ge ? (t - radix_r) : t;
    end
    mag_nxt = q;
    rem_nxt = r[DIGIT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mag_r <= '0;
      rem_r <= '0;
      neg_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (cmd.load) begin
        neg_r <= in_number[NUM_W-1];
        mag_r <= in_number[NUM_W-1] ? (NUM_W'(0) - in_number) : in_number;
        rem_r <= '0;
        cnt_r <= '0;
      end else if (cmd.div_step) begin
        mag_r <= mag_nxt;
        rem_r <= cmd.div_last ? '0 : rem_nxt;
        if (cmd.div_last) begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
      end else if (cmd.out_digit) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  assign rd_addr = ADDR_W'(cnt_r - CNT_W'(1));

  always_ff @(posedge clk) begin
    if (cmd.div_step && cmd.div_last) begin
      store[cnt_r[ADDR_W-1:0]] <= rem_nxt;
    end
    if (cmd.rd) begin
      rd_data_r <= store[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_sign || cmd.out_digit || cmd.out_err) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    priority if (cmd.out_err) begin
      out_symbol_r <= '0;
      out_last_r   <= 1'b1;
      out_inv_r    <= 1'b1;
    end else if (cmd.out_sign) begin
      out_symbol_r <= SIGN_MINUS;
      out_last_r   <= 1'b0;
      out_inv_r    <= 1'b0;
    end else if (cmd.out_digit) begin
      out_symbol_r <= sym[rd_data_r];
      out_last_r   <= (cnt_r == CNT_W'(1));
      out_inv_r    <= 1'b0;
    end else begin
    end
  end

  assign sts.alpha_ok  = alpha_ok;
  assign sts.neg       = neg_r;
  assign sts.out_free  = !out_valid_r || !out_stall;
  assign sts.quot_zero = (mag_nxt == '0);
  assign sts.cnt_full  = (cnt_r == CNT_W'(STORE_DEPTH - 1));
  assign sts.cnt_one   = (cnt_r == CNT_W'(1));

  assign out_valid            = out_valid_r;
  assign out_symbol           = out_symbol_r;
  assign out_last             = out_last_r;
  assign out_alphabet_invalid = out_inv_r;

endmodule

// File: sv/sirs_ctrl.sv
// Controller of the radix converter: sequences check, division, sign and
// symbol output. Depends on sirs_pkg; drives the datapath in sirs_dp.
`timescale 1ns / 1ps

module sirs_ctrl import sirs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  sirs_sts_t sts,
  output sirs_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_SIGN  = 3'd3;
  localparam logic [2:0] S_RD    = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0]        state_r;
  logic [2:0]        state_nxt;
  logic [STEP_W-1:0] step_r;
  logic [STEP_W-1:0] step_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        step_nxt = '0;
        if (sts.alpha_ok) begin
          state_nxt = S_DIV;
        end else if (sts.out_free) begin
          cmd.out_err = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cmd.div_last = (step_r == STEP_W'(DIV_CYCLES - 1));
        step_nxt     = step_r + STEP_W'(1);
        // A digit is complete after the last slice; stop once the quotient
        // reaches zero or the store is full.
        if (cmd.div_last && (sts.quot_zero || sts.cnt_full)) begin
          state_nxt = S_SIGN;
        end
      end
      S_SIGN: begin
        if (!sts.neg) begin
          state_nxt = S_RD;
        end else if (sts.out_free) begin
          cmd.out_sign = 1'b1;
          state_nxt    = S_RD;
        end
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.out_digit = 1'b1;
          state_nxt     = sts.cnt_one ? S_IDLE : S_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  a_out_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.out_sign, cmd.out_digit, cmd.out_err}))
    else $error("more than one output load in a cycle");

  a_out_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_sign || cmd.out_digit || cmd.out_err) |-> sts.out_free)
    else $error("output register loaded while a result is still held");

  a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_CHECK))
    else $error("accepted item did not move to the alphabet check");

  a_last_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_last |-> (cmd.div_step && step_r == STEP_W'(DIV_CYCLES - 1)))
    else $error("digit completed outside the final divider slice");

endmodule

// File: dv/signed_int_to_radix_symbols_test.sv
// Self-checking testbench for the signed integer to radix symbol converter.
// Drives directed and random numbers and alphabets and checks every output symbol.
// Depends on sirs_pkg and signed_int_to_radix_symbols.
`timescale 1ns / 1ps

module signed_int_to_radix_symbols_test;
  import sirs_pkg::*;

  localparam int unsigned TIMEOUT_NS = 9_000_000;
  localparam int unsigned ITEM_TOTAL = 430;

  typedef enum logic {ROW_CFG, ROW_NUM} row_kind_t;

  // Directed stimulus row. When typed is set, the expected output is taken from
  // err/text instead of the predictor; text holds the characters right-justified.
  typedef struct packed {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   index;
    logic [CFG_DATA_W-1:0]  data;
    logic [NUM_W-1:0]       number;
    logic                   typed;
    logic                   err;
    logic [8*12-1:0]        text;
  } row_t;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last;
    logic             invalid;
  } symbol_result_t;

  // Out of reset symbols 8 and 9 are zero bytes, so radix 10 is rejected until
  // the high word supplies them.
  localparam row_t DIRECTED_ROWS [46] = '{
    '{ROW_NUM, REG_RADIX,  64'd0,                 32'd0,         1'b1, 1'b1, 96'd0},
    '{ROW_NUM, REG_RADIX,  64'd0,                 32'h8000_0000, 1'b1, 1'b1, 96'd0},
    '{ROW_CFG, REG_SYM_HI, 64'h3938,              32'd0,         1'b0, 1'b0, 96'd0},
    '{ROW_NUM, REG_RADIX,  64'd0,                 32'd0,         1'b1, 1'b0, "0"},
    '{ROW_NUM, REG_RADIX,  64'd0,                 32'h7FFF_FFFF, 1'b1, 1'b0, "2147483647"},
    '{ROW_NUM, REG_RADIX,  64'd0,                 32'h8000_0000, 1'b1, 1'b0, "-2147483648"},
    '{ROW_NUM, REG_RADIX,  64'd0,                 32'hFFFF_FFFF, 1'b1, 1'b0, "-1"},
    '{ROW_NUM, REG_RADIX,  64'd0,                 32'd1234,      1'b1, 1'b0, "1234"},
    '{ROW_CFG, REG_RADIX,  64'd16,                32'd0,         1'b0, 1'b0, 96'd0},
    '{ROW_CFG, REG_SYM_HI, 64'h4645_4443_4241_3938, 32'd0,       1'b0, 1'b0, 96'd0},
    '{ROW_NUM, REG_RADIX,  64'd0,                 32'h8000_0000, 1'b1, 1'b0, "-80000000"},
    '{ROW_NUM, REG_RADIX,  64'd0,                 32'h7FFF_FFFF, 1'b1, 1'b0, "7FFFFFFF"},
    '{ROW_NUM, REG_RADIX,  64'd0,                 32'hFFFF_FFF1, 1'b1, 1'b0, "-F"},
    '{ROW_CFG, REG_RADIX,  64'd2,                 32'd0,         1'b0, 1'b0, 96'd0},
    '{ROW_NUM, REG_RADIX,  64'd0,                 32'h8000_0000, 1'b0, 1'b0, 96'd0},
    '{ROW_NUM, REG_RADIX,  64'd0,                 32'h7FFF_FFFF, 1'b0, 1'b0, 96'd0},
    '{ROW_NUM, REG_RADIX,  64'd0,                 32'd0,         1'b1, 1'b0, "0"},
    '{ROW_CFG, REG_RADIX,  64'd3,                 32'd0,         1'b0, 1'b0, 96'd0},
    '{ROW_CFG, REG_SYM_LO, 64'h2D2B_0000_0080_01FF, 32'd0,       1'b0, 1'b0, 96'd0},
    '{ROW_NUM, REG_RADIX,  64'd0,                 32'hFFFF_FF85, 1'b0, 1'b0, 96'd0},
    '{ROW_NUM, REG_RADIX,  64'd0,                 32'h0001_E240, 1'b0, 1'b0, 96'd0},
    '{ROW_CFG, REG_RADIX,  64'd0,                 32'd0,         1'b0, 1'b0, 96'd0},
    '{ROW_NUM, REG_RADIX,  64'd0,                 32'd5,         1'b1, 1'b1, 96'd0},
    '{ROW_CFG, REG_RADIX,  64'd1,                 32'd0,         1'b0, 1'b0, 96'd0},
    '{ROW_NUM, REG_RADIX,  64'd0,                 32'hFFFF_FFFF, 1'b1, 1'b1, 96'd0},
    '{ROW_CFG, REG_RADIX,  64'd17,                32'd0,         1'b0, 1'b0, 96'd0},
    '{ROW_NUM, REG_RADIX,  64'd0,                 32'h7FFF_FFFF, 1'b1, 1'b1, 96'd0},
    '{ROW_CFG, REG_RADIX,  64'd31,                32'd0,         1'b0, 1'b0, 96'd0},
    '{ROW_NUM, REG_RADIX,  64'd0,                 32'h8000_0000, 1'b1, 1'b1, 96'd0},
    '{ROW_CFG, REG_SYM_LO, 64'h3736_3534_3331_3130, 32'd0,       1'b0, 1'b0, 96'd0},
    '{ROW_CFG, REG_RADIX,  64'd4,                 32'd0,         1'b0, 1'b0, 96'd0},
    '{ROW_NUM, REG_RADIX,  64'd0,                 32'd0,         1'b1, 1'b1, 96'd0},
    '{ROW_CFG, REG_SYM_LO, 64'h3736_3534_2B32_3130, 32'd0,       1'b0, 1'b0, 96'd0},
    '{ROW_NUM, REG_RADIX,  64'd0,                 32'd1,         1'b1, 1'b1, 96'd0},
    '{ROW_CFG, REG_SYM_LO, 64'h3736_3534_2D32_3130, 32'd0,       1'b0, 1'b0, 96'd0},
    '{ROW_NUM, REG_RADIX,  64'd0,                 32'd2,         1'b1, 1'b1, 96'd0},
    '{ROW_CFG, REG_SYM_LO, 64'h3736_3534_0032_3130, 32'd0,       1'b0, 1'b0, 96'd0},
    '{ROW_NUM, REG_RADIX,  64'd0,                 32'd3,         1'b1, 1'b1, 96'd0},
    '{ROW_CFG, REG_SYM_LO, 64'h3736_3534_3332_3130, 32'd0,       1'b0, 1'b0, 96'd0},
    '{ROW_CFG, REG_RADIX,  64'd16,                32'd0,         1'b0, 1'b0, 96'd0},
    '{ROW_CFG, REG_SYM_HI, 64'h0045_4443_4241_3938, 32'd0,       1'b0, 1'b0, 96'd0},
    '{ROW_NUM, REG_RADIX,  64'd0,                 32'd10,        1'b1, 1'b1, 96'd0},
    '{ROW_CFG, REG_SYM_HI, 64'h4645_4443_4241_3930, 32'd0,       1'b0, 1'b0, 96'd0},
    '{ROW_NUM, REG_RADIX,  64'd0,                 32'd11,        1'b1, 1'b1, 96'd0},
    '{ROW_CFG, REG_SYM_HI, 64'h4645_4443_4241_3938, 32'd0,       1'b0, 1'b0, 96'd0},
    '{ROW_NUM, REG_RADIX,  64'd0,                 32'hDEAD_BEEF, 1'b1, 1'b0, "-21524111"}
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_RADIX;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [NUM_W-1:0]      in_number = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [SYM_W-1:0]      out_symbol;
  logic                  out_last;
  logic                  out_alphabet_invalid;

  // Shadow copy of the configuration as the block should see it.
  logic [RADIX_W-1:0]    radix_cfg = RADIX_RST;
  logic [CFG_DATA_W-1:0] alpha_lo_cfg = SYM_LO_RST;
  logic [CFG_DATA_W-1:0] alpha_hi_cfg = SYM_HI_RST;

  symbol_result_t due_symbols[$];
  int             mismatches = 0;
  int             in_gap_max = 7;
  int             out_gap_max = 7;

  signed_int_to_radix_symbols DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_number            (in_number),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_symbol           (out_symbol),
    .out_last             (out_last),
    .out_alphabet_invalid (out_alphabet_invalid)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("signed_int_to_radix_symbols_test NOT OK");
    $finish;
  end

  function automatic logic [SYM_W-1:0] alphabet_symbol(input int idx);
    logic [2*CFG_DATA_W-1:0] both;
    both = {alpha_hi_cfg, alpha_lo_cfg};
    return both[idx*SYM_W +: SYM_W];
  endfunction

  function automatic bit alphabet_valid();
    logic [SYM_W-1:0] s;
    if (radix_cfg < 2 || radix_cfg > MAX_SYMBOLS) return 1'b0;
    for (int i = 0; i < radix_cfg; i++) begin
      s = alphabet_symbol(i);
      if (s == 8'h00 || s == SIGN_MINUS || s == SIGN_PLUS) return 1'b0;
      for (int j = 0; j < i; j++)
        if (alphabet_symbol(j) == s) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Queues the symbols that one accepted number must produce.
  task automatic convert_number(input logic [NUM_W-1:0] raw);
    logic [NUM_W-1:0]   mag;
    logic [DIGIT_W-1:0] digits [STORE_DEPTH];
    int                 count;
    if (!alphabet_valid()) begin
      due_symbols.push_back('{8'h00, 1'b1, 1'b1});
      return;
    end
    // The most negative value wraps to 2^31, which still fits unsigned.
    mag = raw[NUM_W-1] ? 32'd0 - raw : raw;
    count = 0;
    do begin
      digits[count] = DIGIT_W'(mag % radix_cfg);
      mag = mag / radix_cfg;
      count++;
    end while (mag != 0 && count < STORE_DEPTH);
    if (raw[NUM_W-1]) due_symbols.push_back('{SIGN_MINUS, 1'b0, 1'b0});
    for (int i = count; i > 0; i--)
      due_symbols.push_back('{alphabet_symbol(digits[i-1]), i == 1, 1'b0});
  endtask

  // Holds the sender off until every queued symbol has come out.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (due_symbols.size() != 0);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                input logic [CFG_DATA_W-1:0] data);
    wait_idle();
    repeat (2) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (index)
      REG_RADIX:  radix_cfg = data[RADIX_W-1:0];
      REG_SYM_LO: alpha_lo_cfg = data;
      REG_SYM_HI: alpha_hi_cfg = data;
      default: ;
    endcase
  endtask

  // Returns in the time step at which the number was accepted.
  task automatic send_number(input logic [NUM_W-1:0] value);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_number <= value;
    do @(posedge clk); while (in_stall);
  endtask

  // Result side: checks each accepted symbol and draws a stall after it.
  initial begin
    symbol_result_t want;
    int             hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (due_symbols.size() == 0) begin
          $display("%0t: unexpected item, got symbol %02h last %0b invalid %0b",
                   $time, out_symbol, out_last, out_alphabet_invalid);
          mismatches++;
        end else begin
          want = due_symbols.pop_front();
          if (out_symbol !== want.symbol) begin
            $display("%0t: symbol expected %02h got %02h", $time, want.symbol, out_symbol);
            mismatches++;
          end
          if (out_last !== want.last) begin
            $display("%0t: last expected %0b got %0b", $time, want.last, out_last);
            mismatches++;
          end
          if (out_alphabet_invalid !== want.invalid) begin
            $display("%0t: alphabet_invalid expected %0b got %0b",
                     $time, want.invalid, out_alphabet_invalid);
            mismatches++;
          end
        end
        hold = $urandom_range(0, out_gap_max);
      end else if (hold != 0) begin
        hold--;
      end
      out_stall <= (hold != 0);
    end
  end

  initial begin
    row_t                    row;
    logic [2*CFG_DATA_W-1:0] alpha;
    logic [SYM_W-1:0]        b;
    logic [RADIX_W-1:0]      r;
    logic [NUM_W-1:0]        value;
    bit                      clash;
    int                      kind, pos, phase_len, items_sent;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    items_sent = 0;
    for (int i = 0; i < $size(DIRECTED_ROWS); i++) begin
      row = DIRECTED_ROWS[i];
      if (row.kind == ROW_CFG) begin
        write_register(row.index, row.data);
      end else begin
        send_number(row.number);
        items_sent++;
        if (!row.typed) begin
          convert_number(row.number);
        end else if (row.err) begin
          due_symbols.push_back('{8'h00, 1'b1, 1'b1});
        end else begin
          for (int k = 11; k >= 0; k--)
            if (row.text[k*8 +: 8] != 8'h00)
              due_symbols.push_back('{row.text[k*8 +: 8], k == 0, 1'b0});
        end
      end
    end

    while (items_sent < ITEM_TOTAL) begin
      kind = $urandom_range(0, 9);
      case ($urandom_range(0, 3))
        0:       r = 5'd2;
        1:       r = 5'd16;
        default: r = RADIX_W'($urandom_range(2, 16));
      endcase
      // Distinct legal symbols below the radix, anything at all above it.
      for (int p = 0; p < ALPHA_N; p++) begin
        if (p < r) begin
          do begin
            b = SYM_W'($urandom_range(1, 255));
            clash = (b == SIGN_PLUS || b == SIGN_MINUS);
            for (int q = 0; q < p; q++)
              if (alpha[q*8 +: 8] == b) clash = 1'b1;
          end while (clash);
        end else begin
          b = SYM_W'($urandom);
        end
        alpha[p*8 +: 8] = b;
      end
      if (kind == 0) begin
        r = RADIX_W'($urandom_range(0, 31));
        alpha = {$urandom, $urandom, $urandom, $urandom};
      end else if (kind == 1) begin
        pos = $urandom_range(0, r - 1);
        case ($urandom_range(0, 3))
          0:       alpha[pos*8 +: 8] = SIGN_PLUS;
          1:       alpha[pos*8 +: 8] = SIGN_MINUS;
          2:       alpha[pos*8 +: 8] = 8'h00;
          default: alpha[pos*8 +: 8] = alpha[((pos + 1) % r)*8 +: 8];
        endcase
      end
      write_register(REG_RADIX, CFG_DATA_W'(r));
      write_register(REG_SYM_LO, alpha[CFG_DATA_W-1:0]);
      write_register(REG_SYM_HI, alpha[2*CFG_DATA_W-1:CFG_DATA_W]);

      in_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 7;
      out_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 7;
      phase_len = (kind <= 1) ? $urandom_range(3, 8) : $urandom_range(8, 30);

      for (int n = 0; n < phase_len && items_sent < ITEM_TOTAL; n++) begin
        case ($urandom_range(0, 7))
          4: value = $urandom_range(0, 40);
          5: value = 32'd0 - $urandom_range(1, 40);
          6: begin
            case ($urandom_range(0, 3))
              0:       value = 32'h8000_0000;
              1:       value = 32'h7FFF_FFFF;
              2:       value = 32'd0;
              default: value = 32'hFFFF_FFFF;
            endcase
          end
          7: begin
            // Vary the digit count by shifting a random value down.
            value = $urandom >> $urandom_range(0, 31);
            if ($urandom_range(0, 1) == 1) value = 32'd0 - value;
          end
          default: value = $urandom;
        endcase
        if ($urandom_range(0, 19) == 0) wait_idle();
        send_number(value);
        convert_number(value);
        items_sent++;
      end
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatches == 0)
      $display("signed_int_to_radix_symbols_test OK");
    else
      $display("signed_int_to_radix_symbols_test NOT OK");
    $finish;
  end

endmodule

// File: sim.f
sv/sirs_pkg.sv
sv/sirs_dp.sv
sv/sirs_ctrl.sv
sv/signed_int_to_radix_symbols.sv
dv/signed_int_to_radix_symbols_test.sv
